@@ hw/rtl/sbep_pkg.sv @@
// ----------------------------------------------------------------------------
// SBEP deframer package
// Shared types and codes for the message deframer controller and datapath.
// ----------------------------------------------------------------------------
package sbep_pkg;

   // Request action codes.
   typedef enum logic [1:0] {
      ACT_PUSH    = 2'd0,
      ACT_EXTRACT = 2'd1,
      ACT_READ    = 2'd2,
      ACT_NOP     = 2'd3
   } action_type;

   // Response status codes.
   typedef enum logic [1:0] {
      STS_OK        = 2'd0,
      STS_NO_MSG    = 2'd1,
      STS_RING_FULL = 2'd2,
      STS_BAD_INDEX = 2'd3
   } status_type;

   // Controller states.
   typedef enum logic [3:0] {
      ST_IDLE,
      ST_POS,
      ST_HDR,
      ST_OPC,
      ST_SIZE,
      ST_SZH,
      ST_SZL,
      ST_LEN,
      ST_SUM,
      ST_NEXT,
      ST_COPY_RD,
      ST_COPY_WR,
      ST_FOUND,
      ST_MISS,
      ST_RESP
   } state_type;

   // Datapath commands, one per cycle.
   typedef enum logic [4:0] {
      CMD_NONE,
      CMD_PUSH,
      CMD_READ,
      CMD_NOP,
      CMD_SCAN_INIT,
      CMD_POS,
      CMD_HDR,
      CMD_OPC,
      CMD_SIZE,
      CMD_SZH,
      CMD_SZL,
      CMD_LEN,
      CMD_SUM,
      CMD_NEXT,
      CMD_COPY_RD,
      CMD_COPY_WR,
      CMD_FOUND,
      CMD_MISS
   } cmd_type;

   // Datapath flags used by the controller for its decisions.
   typedef struct packed {
      logic pos_end;
      logic op_ext;
      logic opc_short;
      logic size_ext;
      logic size_short;
      logic len_bad;
      logic follow_zero;
      logic last_byte;
      logic csum_ok;
      logic copy_done;
   } dp_flags_type;

   localparam logic [3:0] NIBBLE_EXT = 4'hF;
   localparam logic [7:0] CSUM_BASE  = 8'hFF;

endpackage

@@ hw/rtl/sbep_message_deframer_top.sv @@
// ----------------------------------------------------------------------------
// SBEP message deframer
// Byte-stream ring with message resynchronization and a message data store.
// ----------------------------------------------------------------------------
// Usage: one request transfer (req_action, req_byte_in, req_data_index)
// produces exactly one response transfer (status, opcode, data length, data
// byte, fill level). Both channels use valid/stall; a transfer happens on an
// edge with valid high and stall low. One request is handled at a time:
// req_stall is high from acceptance until the response has been taken.
// Push, read and no-op raise rsp_valid in the cycle right after acceptance.
// Extract walks the held bytes through the ring's single read port, trying
// each start position in turn and summing the message bytes of each trial;
// a hit then copies the data bytes into the store, so latency is set by the
// scan and the ring read port. Synchronous reset empties the ring and
// clears the stored message length and opcode; no clearing pass is needed.
// While rsp_stall is high the response holds and no new request is accepted.
module sbep_message_deframer_top #(
   parameter int RING_DEPTH  = 131072,
   parameter int MAX_FOLLOW  = 4096,
   parameter int KEEP_LIMIT  = 65536,
   parameter int TAIL_LENGTH = 8192
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_action,
   input  logic [7:0]  req_byte_in,
   input  logic [11:0] req_data_index,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [1:0]  rsp_status,
   output logic [7:0]  rsp_opcode,
   output logic [11:0] rsp_data_length,
   output logic [7:0]  rsp_data_byte,
   output logic [17:0] rsp_fill_level
);
   import sbep_pkg::*;

   cmd_type      cmd;
   dp_flags_type flags;

   // Controller.
   sbep_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_action (req_action),
      .req_stall  (req_stall),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .flags      (flags),
      .cmd        (cmd)
   );

   // Datapath.
   sbep_dp #(
      .RING_DEPTH  (RING_DEPTH),
      .MAX_FOLLOW  (MAX_FOLLOW),
      .KEEP_LIMIT  (KEEP_LIMIT),
      .TAIL_LENGTH (TAIL_LENGTH)
   ) u_dp (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .flags           (flags),
      .req_byte_in     (req_byte_in),
      .req_data_index  (req_data_index),
      .rsp_status      (rsp_status),
      .rsp_opcode      (rsp_opcode),
      .rsp_data_length (rsp_data_length),
      .rsp_data_byte   (rsp_data_byte),
      .rsp_fill_level  (rsp_fill_level)
   );

   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> req_stall)
      else $error("request accepted while response pending");
   a_bad_index_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status == STS_BAD_INDEX) |-> (rsp_data_byte == 8'h00))
      else $error("data byte returned for bad index");
   a_push_ack: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall && req_action == ACT_PUSH) |=> rsp_valid)
      else $error("push response late");

endmodule

@@ hw/rtl/sbep_ram.sv @@
// ----------------------------------------------------------------------------
// SBEP generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module sbep_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 4096
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port and registered read port; read data holds when not enabled.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ hw/rtl/sbep_ctrl.sv @@
// ----------------------------------------------------------------------------
// SBEP deframer controller
// Sequences push, read and the byte-by-byte message scan of an extract.
// ----------------------------------------------------------------------------
module sbep_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   input  logic [1:0]            req_action,
   output logic                  req_stall,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   input  sbep_pkg::dp_flags_type flags,
   output sbep_pkg::cmd_type     cmd
);
   import sbep_pkg::*;

   state_type state_ff, state_in;
   action_type act;

   assign act = action_type'(req_action);

   // State register.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               state_in = (act == ACT_EXTRACT) ? ST_POS : ST_RESP;
            end
         end
         ST_POS:  state_in = flags.pos_end ? ST_MISS : ST_HDR;
         ST_HDR: begin
            priority if (!flags.op_ext) state_in = ST_SIZE;
            else if (flags.opc_short) state_in = ST_NEXT;
            else state_in = ST_OPC;
         end
         ST_OPC:  state_in = ST_SIZE;
         ST_SIZE: begin
            priority if (!flags.size_ext) state_in = ST_LEN;
            else if (flags.size_short) state_in = ST_NEXT;
            else state_in = ST_SZH;
         end
         ST_SZH:  state_in = ST_SZL;
         ST_SZL:  state_in = ST_LEN;
         ST_LEN: begin
            priority if (flags.len_bad) state_in = ST_NEXT;
            else if (flags.follow_zero) state_in = ST_COPY_RD;
            else state_in = ST_SUM;
         end
         ST_SUM: begin
            if (flags.last_byte) begin
               state_in = flags.csum_ok ? ST_COPY_RD : ST_NEXT;
            end
         end
         ST_NEXT:    state_in = ST_POS;
         ST_COPY_RD: state_in = flags.copy_done ? ST_FOUND : ST_COPY_WR;
         ST_COPY_WR: state_in = ST_COPY_RD;
         ST_FOUND:   state_in = ST_RESP;
         ST_MISS:    state_in = ST_RESP;
         ST_RESP: begin
            if (!rsp_stall) state_in = ST_IDLE;
         end
         default:    state_in = ST_IDLE;
      endcase
   end

   // Outputs: handshake and datapath command.
   always_comb begin
      req_stall = (state_ff != ST_IDLE);
      rsp_valid = (state_ff == ST_RESP);
      cmd       = CMD_NONE;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               unique case (act)
                  ACT_PUSH:    cmd = CMD_PUSH;
                  ACT_EXTRACT: cmd = CMD_SCAN_INIT;
                  ACT_READ:    cmd = CMD_READ;
                  ACT_NOP:     cmd = CMD_NOP;
                  default:     cmd = CMD_NOP;
               endcase
            end
         end
         ST_POS:     cmd = CMD_POS;
         ST_HDR:     cmd = CMD_HDR;
         ST_OPC:     cmd = CMD_OPC;
         ST_SIZE:    cmd = CMD_SIZE;
         ST_SZH:     cmd = CMD_SZH;
         ST_SZL:     cmd = CMD_SZL;
         ST_LEN:     cmd = CMD_LEN;
         ST_SUM:     cmd = CMD_SUM;
         ST_NEXT:    cmd = CMD_NEXT;
         ST_COPY_RD: cmd = CMD_COPY_RD;
         ST_COPY_WR: cmd = CMD_COPY_WR;
         ST_FOUND:   cmd = CMD_FOUND;
         ST_MISS:    cmd = CMD_MISS;
         ST_RESP:    cmd = CMD_NONE;
         default:    cmd = CMD_NONE;
      endcase
   end

   // A transfer is accepted only from idle, and a response only leaves from the response state.
   a_accept_idle: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> (state_ff == ST_POS || state_ff == ST_RESP))
      else $error("accepted request did not start work");
   a_resp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> rsp_valid)
      else $error("response dropped while stalled");
   a_scan_ends: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_FOUND || state_ff == ST_MISS) |=> (state_ff == ST_RESP))
      else $error("scan end did not produce a response");

endmodule

@@ hw/rtl/sbep_dp.sv @@
// ----------------------------------------------------------------------------
// SBEP deframer datapath
// Stream ring, message store, scan registers and response registers.
// ----------------------------------------------------------------------------
module sbep_dp #(
   parameter int RING_DEPTH  = 131072,
   parameter int MAX_FOLLOW  = 4096,
   parameter int KEEP_LIMIT  = 65536,
   parameter int TAIL_LENGTH = 8192
) (
   input  logic                   clock,
   input  logic                   reset,
   input  sbep_pkg::cmd_type      cmd,
   output sbep_pkg::dp_flags_type flags,
   input  logic [7:0]             req_byte_in,
   input  logic [11:0]            req_data_index,
   output logic [1:0]             rsp_status,
   output logic [7:0]             rsp_opcode,
   output logic [11:0]            rsp_data_length,
   output logic [7:0]             rsp_data_byte,
   output logic [17:0]            rsp_fill_level
);
   import sbep_pkg::*;

   localparam int AW  = $clog2(RING_DEPTH);
   localparam int CW  = $clog2(RING_DEPTH + 1);
   localparam int EW  = ((CW > 16) ? CW : 16) + 1;
   localparam int SAW = $clog2(MAX_FOLLOW);
   localparam int IXW = (SAW > 12) ? SAW : 12;

   // Ring bookkeeping and stored message.
   logic [AW-1:0]  head_ff, head_in;
   logic [CW-1:0]  count_ff, count_in;
   logic [SAW-1:0] msg_len_ff, msg_len_in;
   logic [7:0]     msg_op_ff, msg_op_in;
   // Scan registers.
   logic [CW-1:0]  pos_ff, pos_in;
   logic [CW-1:0]  idx_ff, idx_in;
   logic [CW-1:0]  cur_ff, cur_in;
   logic [15:0]    follow_ff, follow_in;
   logic [15:0]    cnt_ff, cnt_in;
   logic [7:0]     sum_ff, sum_in;
   logic [7:0]     hdr_ff, hdr_in;
   logic [7:0]     op_ff, op_in;
   logic [SAW-1:0] k_ff, k_in;
   // Response registers.
   status_type     sts_ff, sts_in;
   logic [7:0]     ropc_ff, ropc_in;
   logic [11:0]    rdl_ff, rdl_in;
   logic           rbyte_ff, rbyte_in;

   logic           ring_we, ring_re, store_we, store_re;
   logic [CW-1:0]  ring_off;
   logic [AW-1:0]  ring_raddr, ring_waddr;
   logic [7:0]     ring_rdata, store_rdata;
   logic [SAW-1:0] store_addr;
   logic [IXW-1:0] ix;
   logic [SAW-1:0] dlen;
   logic [EW-1:0]  msg_end;
   logic [CW-1:0]  trim;

   // Head plus an offset, folded back into the ring.
   function automatic logic [AW-1:0] wrap_add(input logic [AW-1:0] base,
                                             input logic [CW-1:0] off);
      logic [CW:0] s;
      s = (CW+1)'(base) + (CW+1)'(off);
      if (s >= (CW+1)'(RING_DEPTH)) s = s - (CW+1)'(RING_DEPTH);
      return s[AW-1:0];
   endfunction

   assign ix      = IXW'(req_data_index);
   assign dlen    = (follow_ff == 16'd0) ? '0 : SAW'(follow_ff - 16'd1);
   assign msg_end = EW'(idx_ff) + EW'(follow_ff);
   assign trim    = count_ff - CW'(TAIL_LENGTH);

   // Flags for the controller.
   always_comb begin
      flags.pos_end     = (pos_ff >= count_ff);
      flags.op_ext      = (ring_rdata[7:4] == NIBBLE_EXT);
      flags.opc_short   = (idx_ff >= count_ff);
      flags.size_ext    = (hdr_ff[3:0] == NIBBLE_EXT);
      flags.size_short  = ((CW+1)'(idx_ff) + (CW+1)'(1) >= (CW+1)'(count_ff));
      flags.len_bad     = (follow_ff > 16'(MAX_FOLLOW)) || (msg_end > EW'(count_ff));
      flags.follow_zero = (follow_ff == 16'd0);
      flags.last_byte   = (cnt_ff == 16'd1);
      flags.csum_ok     = (ring_rdata == (CSUM_BASE - sum_ff));
      flags.copy_done   = (k_ff >= dlen);
   end

   // Ring read offset for the scan.
   always_comb begin
      ring_re  = 1'b1;
      ring_off = idx_ff;
      unique case (cmd)
         CMD_POS:     ring_off = pos_ff;
         CMD_HDR:     ring_off = idx_ff;
         CMD_SIZE:    ring_off = idx_ff;
         CMD_SZH:     ring_off = idx_ff + CW'(1);
         CMD_LEN:     ring_off = idx_ff;
         CMD_SUM:     ring_off = cur_ff;
         CMD_COPY_RD: ring_off = idx_ff + CW'(k_ff);
         default:     ring_re  = 1'b0;
      endcase
   end

   assign ring_raddr = wrap_add(head_ff, ring_off);
   assign ring_waddr = wrap_add(head_ff, count_ff);
   assign ring_we    = (cmd == CMD_PUSH) && (count_ff < CW'(RING_DEPTH));
   assign store_we   = (cmd == CMD_COPY_WR);
   assign store_re   = (cmd == CMD_READ);
   assign store_addr = store_we ? k_ff : ix[SAW-1:0];

   // Next values of all datapath registers.
   always_comb begin
      head_in    = head_ff;
      count_in   = count_ff;
      msg_len_in = msg_len_ff;
      msg_op_in  = msg_op_ff;
      pos_in     = pos_ff;
      idx_in     = idx_ff;
      cur_in     = cur_ff;
      follow_in  = follow_ff;
      cnt_in     = cnt_ff;
      sum_in     = sum_ff;
      hdr_in     = hdr_ff;
      op_in      = op_ff;
      k_in       = k_ff;
      sts_in     = sts_ff;
      ropc_in    = ropc_ff;
      rdl_in     = rdl_ff;
      rbyte_in   = rbyte_ff;
      unique case (cmd)
         CMD_PUSH: begin
            ropc_in  = '0;
            rdl_in   = '0;
            rbyte_in = 1'b0;
            if (ring_we) begin
               count_in = count_ff + CW'(1);
               sts_in   = STS_OK;
            end else begin
               sts_in   = STS_RING_FULL;
            end
         end
         CMD_READ: begin
            ropc_in  = msg_op_ff;
            rdl_in   = 12'(msg_len_ff);
            rbyte_in = (ix < IXW'(msg_len_ff));
            sts_in   = (ix < IXW'(msg_len_ff)) ? STS_OK : STS_BAD_INDEX;
         end
         CMD_NOP: begin
            ropc_in  = '0;
            rdl_in   = '0;
            rbyte_in = 1'b0;
            sts_in   = STS_OK;
         end
         CMD_SCAN_INIT: pos_in = '0;
         CMD_POS: begin
            idx_in = pos_ff + CW'(1);
            sum_in = '0;
         end
         CMD_HDR: begin
            hdr_in = ring_rdata;
            sum_in = sum_ff + ring_rdata;
            op_in  = {4'h0, ring_rdata[7:4]};
         end
         CMD_OPC: begin
            op_in  = ring_rdata;
            sum_in = sum_ff + ring_rdata;
            idx_in = idx_ff + CW'(1);
         end
         CMD_SIZE: begin
            if (hdr_ff[3:0] != NIBBLE_EXT) follow_in = {12'h000, hdr_ff[3:0]};
         end
         CMD_SZH: begin
            follow_in = {ring_rdata, follow_ff[7:0]};
            sum_in    = sum_ff + ring_rdata;
            idx_in    = idx_ff + CW'(1);
         end
         CMD_SZL: begin
            follow_in = {follow_ff[15:8], ring_rdata};
            sum_in    = sum_ff + ring_rdata;
            idx_in    = idx_ff + CW'(1);
         end
         CMD_LEN: begin
            cur_in = idx_ff + CW'(1);
            cnt_in = follow_ff;
            k_in   = '0;
         end
         CMD_SUM: begin
            sum_in = sum_ff + ring_rdata;
            cur_in = cur_ff + CW'(1);
            cnt_in = cnt_ff - 16'd1;
         end
         CMD_NEXT:    pos_in = pos_ff + CW'(1);
         CMD_COPY_WR: k_in = k_ff + SAW'(1);
         CMD_FOUND: begin
            head_in    = wrap_add(head_ff, CW'(msg_end));
            count_in   = count_ff - CW'(msg_end);
            msg_len_in = dlen;
            msg_op_in  = op_ff;
            ropc_in    = op_ff;
            rdl_in     = 12'(dlen);
            rbyte_in   = 1'b0;
            sts_in     = STS_OK;
         end
         CMD_MISS: begin
            ropc_in  = '0;
            rdl_in   = '0;
            rbyte_in = 1'b0;
            sts_in   = STS_NO_MSG;
            if (32'(count_ff) > 32'(KEEP_LIMIT) && 32'(count_ff) > 32'(TAIL_LENGTH)) begin
               head_in  = wrap_add(head_ff, trim);
               count_in = CW'(TAIL_LENGTH);
            end
         end
         default: ;
      endcase
   end

   // Control registers with reset.
   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff    <= '0;
         count_ff   <= '0;
         msg_len_ff <= '0;
         msg_op_ff  <= '0;
      end else begin
         head_ff    <= head_in;
         count_ff   <= count_in;
         msg_len_ff <= msg_len_in;
         msg_op_ff  <= msg_op_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      pos_ff    <= pos_in;
      idx_ff    <= idx_in;
      cur_ff    <= cur_in;
      follow_ff <= follow_in;
      cnt_ff    <= cnt_in;
      sum_ff    <= sum_in;
      hdr_ff    <= hdr_in;
      op_ff     <= op_in;
      k_ff      <= k_in;
      sts_ff    <= sts_in;
      ropc_ff   <= ropc_in;
      rdl_ff    <= rdl_in;
      rbyte_ff  <= rbyte_in;
   end

   // Stream ring memory.
   sbep_ram #(.WIDTH(8), .DEPTH(RING_DEPTH)) u_ring (
      .clock   (clock),
      .wr_en   (ring_we),
      .wr_addr (ring_waddr),
      .wr_data (req_byte_in),
      .rd_en   (ring_re),
      .rd_addr (ring_raddr),
      .rd_data (ring_rdata)
   );

   // Message data store.
   sbep_ram #(.WIDTH(8), .DEPTH(MAX_FOLLOW)) u_store (
      .clock   (clock),
      .wr_en   (store_we),
      .wr_addr (store_addr),
      .wr_data (ring_rdata),
      .rd_en   (store_re),
      .rd_addr (store_addr),
      .rd_data (store_rdata)
   );

   // Response outputs.
   assign rsp_status      = sts_ff;
   assign rsp_opcode      = ropc_ff;
   assign rsp_data_length = rdl_ff;
   assign rsp_data_byte   = rbyte_ff ? store_rdata : 8'h00;
   assign rsp_fill_level  = 18'(count_ff);

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(RING_DEPTH))
      else $error("ring count above depth");
   a_found_shrinks: assert property (@(posedge clock) disable iff (reset)
      (cmd == CMD_FOUND) |=> (count_ff < $past(count_ff)))
      else $error("extracted message did not consume bytes");
   a_store_access: assert property (@(posedge clock) disable iff (reset)
      !(store_we && store_re))
      else $error("store read and written together");

endmodule
